>>> design/pfc_pkg.sv
package pfc_pkg;

    localparam int NUM_PLANES = 4;
    localparam int COORD_W    = 24;
    localparam int NORM_W     = 16;
    localparam int OFFSET_W   = 32;
    localparam int FRAC_SHIFT = 14;
    localparam int PROD_W     = COORD_W + NORM_W;
    localparam int THR_W      = OFFSET_W + FRAC_SHIFT;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 3 * NORM_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_PLANE0_NORMAL = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_PLANE0_OFFSET = CFG_ADDR_W'(NUM_PLANES);
    localparam logic [CFG_ADDR_W-1:0] CFG_END           = CFG_ADDR_W'(2 * NUM_PLANES);

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic                      last_vertex;
    } pfc_vertex_t;

    typedef struct packed {
        logic                  visible;
        logic [NUM_PLANES-1:0] plane_pass_mask;
    } pfc_result_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] z;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] x;
    } pfc_normal_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
        logic signed [PROD_W-1:0] pz;
    } pfc_products_t;

    typedef struct packed {
        pfc_products_t [NUM_PLANES-1:0] prod;
        logic                           last_vertex;
    } pfc_mid_t;

endpackage

>>> design/pfc_fifo.sv
module pfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> design/pfc_front.sv
module pfc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pfc_pkg::pfc_vertex_t vertex,
    output logic                 full,
    input  pfc_pkg::pfc_normal_t normals [pfc_pkg::NUM_PLANES],
    output logic                 mid_push,
    output pfc_pkg::pfc_mid_t    mid_item,
    input  logic                 mid_full
);

    import pfc_pkg::*;

    logic     valid_reg, valid_next;
    pfc_mid_t item_reg, item_next;
    logic     advance, accept;

    assign advance  = !valid_reg || !mid_full;
    assign accept   = push && advance;
    assign full     = !advance;
    assign mid_push = valid_reg && !mid_full;
    assign mid_item = item_reg;

    // one product per axis per plane, all independent
    always_comb
    begin
        item_next.last_vertex = vertex.last_vertex;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            item_next.prod[p].px = vertex.vert_x * normals[p].x;
            item_next.prod[p].py = vertex.vert_y * normals[p].y;
            item_next.prod[p].pz = vertex.vert_z * normals[p].z;
        end
        valid_next = advance ? push : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> design/pfc_back.sv
module pfc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mid_empty,
    input  pfc_pkg::pfc_mid_t             mid_item,
    output logic                          mid_pop,
    input  logic signed [pfc_pkg::OFFSET_W-1:0] offsets [pfc_pkg::NUM_PLANES],
    input  logic                          out_full,
    output logic                          out_push,
    output pfc_pkg::pfc_result_t          out_item
);

    import pfc_pkg::*;

    logic [NUM_PLANES-1:0]   flags_reg, flags_next;
    logic [NUM_PLANES-1:0]   pass;
    logic [NUM_PLANES-1:0]   seen;
    logic signed [THR_W-1:0] dot [NUM_PLANES];
    logic signed [THR_W-1:0] thr [NUM_PLANES];

    assign mid_pop  = !mid_empty && (!mid_item.last_vertex || !out_full);
    assign out_push = mid_pop && mid_item.last_vertex;

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            dot[p]  = THR_W'(mid_item.prod[p].px) + THR_W'(mid_item.prod[p].py)
                      + THR_W'(mid_item.prod[p].pz);
            thr[p]  = {offsets[p], {FRAC_SHIFT{1'b0}}};
            pass[p] = (dot[p] >= thr[p]);
        end
        seen                     = flags_reg | pass;
        out_item.plane_pass_mask = seen;
        out_item.visible         = &seen;
        flags_next               = flags_reg;
        if (mid_pop)
        begin
            flags_next = mid_item.last_vertex ? '0 : seen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

endmodule

>>> design/polygon_frustum_cull.sv
// channel   direction  handshake              payload
// vertex    in         push / full            pfc_vertex_t
// result    out        pop / empty            pfc_result_t
// config    in         cfg_we, cfg_addr       cfg_wdata (48 bits)
//
// One vertex per cycle sustained while full stays low; an accepted vertex moves on in steps:
// products registered, then queued, then sum, compare and flag update.
// A closing vertex writes its result at the edge it leaves the queue; it can be popped next cycle.
// Reset clears configuration, pass flags and both queues; no clearing pass.
// Output stall backs up the result queue, then the product queue, then full.
module polygon_frustum_cull #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  pfc_pkg::pfc_vertex_t               vertex,
    output logic                               full,
    input  logic                               pop,
    output pfc_pkg::pfc_result_t               result,
    output logic                               empty,
    input  logic                               cfg_we,
    input  logic [pfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import pfc_pkg::*;

    pfc_normal_t             normal_reg [NUM_PLANES];
    logic signed [OFFSET_W-1:0] offset_reg [NUM_PLANES];
    logic [CFG_ADDR_W-1:0]   normal_idx, offset_idx;

    logic        front_valid;
    logic        mid_push, mid_full, mid_pop, mid_empty;
    pfc_mid_t    front_item, mid_item;
    logic        out_push, out_full;
    pfc_result_t out_item;

    assign normal_idx = cfg_addr - CFG_PLANE0_NORMAL;
    assign offset_idx = cfg_addr - CFG_PLANE0_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                normal_reg[p] <= '0;
                offset_reg[p] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr < CFG_PLANE0_OFFSET)
            begin
                normal_reg[normal_idx[$clog2(NUM_PLANES)-1:0]] <= cfg_wdata;
            end
            else if (cfg_addr < CFG_END)
            begin
                offset_reg[offset_idx[$clog2(NUM_PLANES)-1:0]] <= cfg_wdata[OFFSET_W-1:0];
            end
        end
    end

    pfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .vertex   (vertex),
        .full     (full),
        .normals  (normal_reg),
        .mid_push (mid_push),
        .mid_item (front_item),
        .mid_full (mid_full)
    );

    pfc_fifo #(
        .WIDTH ($bits(pfc_mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (mid_push),
        .din   (front_item),
        .full  (mid_full),
        .rd_en (mid_pop),
        .dout  (mid_item),
        .empty (mid_empty)
    );

    pfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop),
        .offsets   (offset_reg),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    pfc_fifo #(
        .WIDTH ($bits(pfc_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (out_push),
        .din   (out_item),
        .full  (out_full),
        .rd_en (pop),
        .dout  (result),
        .empty (empty)
    );

    // front holds an item whenever it is pushing or stalled on the queue
    assign front_valid = mid_push || (full && mid_full);

    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> front_valid)
        else $error("accepted vertex not held in front stage");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> mid_pop && mid_item.last_vertex && !mid_empty)
        else $error("result pushed without a closing vertex");

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_push && out_full))
        else $error("result queue overflow");

endmodule
